// File: sv/srp_pkg.sv
// Package for the segment relocation patcher.
// Holds the transaction structs, the operation and status codes and the fixed
// constants. Every other file of the block depends on it.
package srp_pkg;

    // Operation codes of an input transaction.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_RELOC = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    // Status codes of a result transaction.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERRUN = 2'd1;
    localparam logic [1:0] ST_ODD     = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEXT_PAGES = 2'd0;
    localparam logic [1:0] CFG_RO_PAGES   = 2'd1;

    // Segment codes of a start-run transaction.
    localparam logic [1:0] SEG_TEXT = 2'd0;
    localparam logic [1:0] SEG_RO   = 2'd1;

    // Image layout constants.
    localparam logic [31:0] IMAGE_BASE  = 32'h0010_0000;
    localparam logic [31:0] OFFSET_MASK = 32'h0FFF_FFFF;
    localparam logic [31:0] REL_MASK    = 32'h7FFF_FFFF;
    localparam int          PAGE_SHIFT_WORDS = 10;   // 4 KiB page is 1024 words

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] word_addr;
        logic [31:0] word_value;
        logic [1:0]  segment;
        logic        reloc_kind;
        logic [15:0] skip_count;
        logic [15:0] patch_count;
    } srp_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
    } srp_out_t;

    // Classified command as it travels from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic        idx_ok;
        logic [15:0] word_addr;
        logic [31:0] word_value;
        logic [1:0]  segment;
        logic        reloc_kind;
        logic [15:0] skip_count;
        logic [15:0] patch_count;
    } srp_cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_WRITE,
        BK_READ_ISSUE,
        BK_READ_DONE,
        BK_START,
        BK_REL_INIT,
        BK_PATCH_CHECK,
        BK_PATCH_MAP,
        BK_PATCH_WRITE
    } back_state_t;

endpackage

// File: sv/srp_front.sv
// Front end of the segment relocation patcher: accepts command transactions,
// classifies them and hands them to the command queue. Depends on srp_pkg.
module srp_front #(
    parameter int MEMORY_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  srp_pkg::srp_in_t   item,
    input  logic               q_full,
    output logic               q_push,
    output srp_pkg::srp_cmd_t  q_data
);

    localparam logic [31:0] MEM_WORDS_32 = 32'(MEMORY_WORDS);

    logic              valid_reg, valid_next;
    srp_pkg::srp_cmd_t cmd_reg, cmd_next;
    srp_pkg::srp_cmd_t classified;
    logic              accept;

    always_comb
    begin
        classified.op          = srp_pkg::op_t'(item.operation);
        classified.idx_ok      = (32'(item.word_addr) < MEM_WORDS_32);
        classified.word_addr   = item.word_addr;
        classified.word_value  = item.word_value;
        classified.segment     = item.segment;
        classified.reloc_kind  = item.reloc_kind;
        classified.skip_count  = item.skip_count;
        classified.patch_count = item.patch_count;
    end

    assign q_push = valid_reg && !q_full;
    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign q_data = cmd_reg;

    always_comb
    begin
        valid_next = accept || (valid_reg && !q_push);
        cmd_next   = accept ? classified : cmd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// File: sv/srp_queue.sv
// Two-entry command queue between the front end and the back end of the
// segment relocation patcher. Depends on srp_pkg.
module srp_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srp_pkg::srp_cmd_t  push_data,
    output logic               full,
    input  logic               pop,
    output srp_pkg::srp_cmd_t  pop_data,
    output logic               empty
);

    localparam int IDX_W = $clog2(srp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(srp_pkg::QUEUE_DEPTH + 1);

    srp_pkg::srp_cmd_t entry_reg [srp_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(srp_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == srp_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == srp_pkg::QUEUE_DEPTH - 1) ? '0
                                                                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/srp_back.sv
// Back end of the segment relocation patcher: program word memory, patch
// pointer and the sequencer that carries out queued commands. Depends on srp_pkg.
module srp_back #(
    parameter int MEMORY_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [6:0]         text_pages,
    input  logic [6:0]         ro_pages,
    input  logic               q_empty,
    input  srp_pkg::srp_cmd_t  q_data,
    output logic               q_pop,
    output logic               done,
    output srp_pkg::srp_out_t  result
);

    localparam int          ADDR_W       = $clog2(MEMORY_WORDS);
    localparam int          PTR_W        = $clog2(MEMORY_WORDS + 1);
    localparam logic [31:0] MEM_WORDS_32 = 32'(MEMORY_WORDS);

    logic [31:0] mem_array [MEMORY_WORDS];
    logic [31:0] mem_rdata_reg;
    logic        mem_we;
    logic        mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [31:0] mem_wdata;

    srp_pkg::back_state_t state_reg, state_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic              kind_reg, kind_next;
    logic [15:0]       count_reg, count_next;
    logic              odd_reg, odd_next;
    logic              done_reg, done_next;
    srp_pkg::srp_out_t result_reg, result_next;
    srp_pkg::srp_cmd_t cmd_reg, cmd_next;
    logic [31:0]       va_reg, va_next;
    logic [31:0]       self_reg, self_next;
    logic [3:0]        sub_reg, sub_next;

    logic [31:0] skip_sum;
    logic [31:0] seg_start;
    logic [31:0] rel_diff;
    logic [31:0] rel_value;

    assign done   = done_reg;
    assign result = result_reg;

    // Pointer after the skip, and the first word of the requested segment.
    assign skip_sum = 32'(ptr_reg) + 32'(cmd_reg.skip_count);

    always_comb
    begin
        case (cmd_reg.segment)
            srp_pkg::SEG_TEXT: seg_start = '0;
            srp_pkg::SEG_RO:   seg_start = 32'(text_pages) << srp_pkg::PAGE_SHIFT_WORDS;
            default:           seg_start = (32'(text_pages) + 32'(ro_pages))
                                           << srp_pkg::PAGE_SHIFT_WORDS;
        endcase
    end

    assign rel_diff  = va_reg - self_reg;
    assign rel_value = (sub_reg != 4'd0) ? (rel_diff & srp_pkg::REL_MASK) : rel_diff;

    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        kind_next   = kind_reg;
        count_next  = count_reg;
        odd_next    = odd_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        cmd_next    = cmd_reg;
        va_next     = va_reg;
        self_next   = self_reg;
        sub_next    = sub_reg;
        q_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = ADDR_W'(32'(cmd_reg.word_addr));
        mem_wdata   = cmd_reg.word_value;

        case (state_reg)
            srp_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    case (q_data.op)
                        srp_pkg::OP_WRITE: state_next = srp_pkg::BK_WRITE;
                        srp_pkg::OP_START: state_next = srp_pkg::BK_START;
                        srp_pkg::OP_RELOC: state_next = srp_pkg::BK_REL_INIT;
                        srp_pkg::OP_READ:  state_next = srp_pkg::BK_READ_ISSUE;
                        default:           state_next = srp_pkg::BK_IDLE;
                    endcase
                end
            end

            srp_pkg::BK_WRITE:
            begin
                mem_we                = cmd_reg.idx_ok;
                done_next             = 1'b1;
                result_next.read_data = '0;
                result_next.status    = cmd_reg.idx_ok ? srp_pkg::ST_OK : srp_pkg::ST_OVERRUN;
                state_next            = srp_pkg::BK_IDLE;
            end

            srp_pkg::BK_READ_ISSUE:
            begin
                if (cmd_reg.idx_ok)
                begin
                    mem_re     = 1'b1;
                    state_next = srp_pkg::BK_READ_DONE;
                end
                else
                begin
                    done_next             = 1'b1;
                    result_next.read_data = '0;
                    result_next.status    = srp_pkg::ST_OVERRUN;
                    state_next            = srp_pkg::BK_IDLE;
                end
            end

            srp_pkg::BK_READ_DONE:
            begin
                done_next             = 1'b1;
                result_next.read_data = mem_rdata_reg;
                result_next.status    = srp_pkg::ST_OK;
                state_next            = srp_pkg::BK_IDLE;
            end

            srp_pkg::BK_START:
            begin
                ptr_next  = (seg_start > MEM_WORDS_32) ? PTR_W'(MEM_WORDS_32)
                                                       : PTR_W'(seg_start);
                kind_next             = cmd_reg.reloc_kind;
                done_next             = 1'b1;
                result_next.read_data = '0;
                result_next.status    = srp_pkg::ST_OK;
                state_next            = srp_pkg::BK_IDLE;
            end

            srp_pkg::BK_REL_INIT:
            begin
                ptr_next   = (skip_sum > MEM_WORDS_32) ? PTR_W'(MEM_WORDS_32)
                                                       : PTR_W'(skip_sum);
                count_next = cmd_reg.patch_count;
                odd_next   = 1'b0;
                state_next = srp_pkg::BK_PATCH_CHECK;
            end

            srp_pkg::BK_PATCH_CHECK:
            begin
                mem_addr = ptr_reg[ADDR_W-1:0];
                if (count_reg == '0)
                begin
                    done_next             = 1'b1;
                    result_next.read_data = '0;
                    result_next.status    = odd_reg ? srp_pkg::ST_ODD : srp_pkg::ST_OK;
                    state_next            = srp_pkg::BK_IDLE;
                end
                else if (32'(ptr_reg) >= MEM_WORDS_32)
                begin
                    // Ran off the end of memory: stop here, pointer stays put.
                    done_next             = 1'b1;
                    result_next.read_data = '0;
                    result_next.status    = srp_pkg::ST_OVERRUN;
                    state_next            = srp_pkg::BK_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = srp_pkg::BK_PATCH_MAP;
                end
            end

            srp_pkg::BK_PATCH_MAP:
            begin
                // The segments sit back to back both in the image and in
                // virtual space, so every offset maps by the same base.
                va_next    = (mem_rdata_reg & srp_pkg::OFFSET_MASK) + srp_pkg::IMAGE_BASE;
                sub_next   = mem_rdata_reg[31:28];
                self_next  = srp_pkg::IMAGE_BASE + (32'(ptr_reg) << 2);
                state_next = srp_pkg::BK_PATCH_WRITE;
            end

            srp_pkg::BK_PATCH_WRITE:
            begin
                mem_addr = ptr_reg[ADDR_W-1:0];
                mem_we   = 1'b1;
                if (kind_reg)
                begin
                    mem_wdata = rel_value;
                    odd_next  = odd_reg || (sub_reg[3:1] != 3'd0);
                end
                else
                begin
                    mem_wdata = va_reg;
                    odd_next  = odd_reg || (sub_reg != 4'd0);
                end
                ptr_next   = ptr_reg + 1'b1;
                count_next = count_reg - 1'b1;
                state_next = srp_pkg::BK_PATCH_CHECK;
            end

            default:
            begin
                state_next = srp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srp_pkg::BK_IDLE;
            ptr_reg   <= '0;
            kind_reg  <= 1'b0;
            count_reg <= '0;
            odd_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            odd_reg   <= odd_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        cmd_reg    <= cmd_next;
        va_reg     <= va_next;
        self_reg   <= self_next;
        sub_reg    <= sub_next;
    end

    // Single-port program memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem_array[mem_addr];
        end
    end

endmodule

// File: sv/segment_relocation_patcher_unit.sv
// Top level of the segment relocation patcher: configuration registers,
// front end, command queue and back end. Depends on srp_pkg, srp_front,
// srp_queue and srp_back.

// A command transaction is taken at a rising edge with start high and busy
// low; each command produces exactly one result transaction, shown on result
// for a single cycle with done high, and the receiver cannot stall it, so
// capture result whenever done is seen. Results come back in command order.
// The front end registers a command and moves it into a two-entry queue, so
// busy only rises when both the front register and the queue are occupied.
// The back end owns a single-port program memory with a registered read, and
// that port sets the pace: a write or a start-run passes its execute state, a
// read an issue and a data state (the issue state alone past the end of
// memory), and a relocation entry an init state, a check, map and write-back
// state per patched word (each word is read, mapped and written back through
// the one port) and a last check. A command passes the front register and the
// queue first, and the result strobe follows in the cycle after the back end's
// last state. The patch pointer starts at zero and the run kind at absolute
// after reset; program memory comes up undefined and must be written before it
// is read or patched. Configuration writes are always ready and are meant to
// be issued only while no command is outstanding.
module segment_relocation_patcher_unit #(
    parameter int MEMORY_WORDS = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    // Command channel.
    input  logic               start,
    output logic               busy,
    input  srp_pkg::srp_in_t   item,
    // Result channel.
    output logic               done,
    output srp_pkg::srp_out_t  result,
    // Configuration write channel.
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    logic [6:0] text_pages_reg, text_pages_next;
    logic [6:0] ro_pages_reg, ro_pages_next;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    srp_pkg::srp_cmd_t push_cmd;
    srp_pkg::srp_cmd_t head_cmd;

    // The register file is a pair of plain registers, so writes never wait.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        text_pages_next = text_pages_reg;
        ro_pages_next   = ro_pages_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srp_pkg::CFG_TEXT_PAGES: text_pages_next = cfg_data;
                srp_pkg::CFG_RO_PAGES:   ro_pages_next   = cfg_data;
                default:
                begin
                    // Writes to indexes past the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_pages_reg <= '0;
            ro_pages_reg   <= '0;
        end
        else
        begin
            text_pages_reg <= text_pages_next;
            ro_pages_reg   <= ro_pages_next;
        end
    end

    // The front end decodes the operation and range-checks the word index
    // once, so the back end only has to act on the classified command.
    srp_front #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (push_cmd)
    );

    srp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head_cmd),
        .empty     (q_empty)
    );

    // The back end holds the patch pointer, the run kind and the memory, and
    // runs one command at a time to completion.
    srp_back #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_pages (text_pages_reg),
        .ro_pages   (ro_pages_reg),
        .q_empty    (q_empty),
        .q_data     (head_cmd),
        .q_pop      (q_pop),
        .done       (done),
        .result     (result)
    );

    // An accepted command is always held by the front end in the next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> q_push || busy || (!q_full && $past(q_full) == 1'b0))
        else $error("accepted command was lost by the front end");

    // The back end never takes a command from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command queue popped while empty");

    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command queue pushed while full");

    // The back end returns to idle between commands, so results never
    // come in adjacent cycles, and the status code is always a defined one.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == srp_pkg::ST_OK || result.status == srp_pkg::ST_OVERRUN ||
                  result.status == srp_pkg::ST_ODD))
        else $error("result carries an undefined status code");

endmodule
